[hdl/stbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search unit.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int LEN_W  = 11;  // table_length register width
    localparam int IDX_W  = 10;  // entry_index width
    localparam int DATA_W = 32;  // table word width
    localparam int POS_W  = 12;  // signed position / search bound width
    localparam int PADDR_W = 2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [PADDR_W-1:0] REG_TABLE_LENGTH = 2'd0;

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
        logic                     floor_mode;
    } t_in_word;

    typedef struct packed {
        logic                    found;
        logic signed [POS_W-1:0] position;
    } t_out_word;

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic ram_wr;      // store the entry of an accepted write word
        logic init;        // load bounds and key, issue first probe read
        logic step;        // evaluate the probe returned by the table
        logic emit_empty;  // empty table: result straight from the request
        logic emit_probe;  // result from the probe evaluated this cycle
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_ok;      // write index lies inside the table
        logic empty;       // effective length is zero
        logic hit;         // probed entry equals the key
        logic exhausted;   // bounds crossed after this probe
    } t_ctrl_sts;

endpackage

[hdl/stbs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/stbs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, search bounds, key compare and result register.
// ----------------------------------------------------------------------------
module stbs_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  stbs_pkg::t_in_word       i_req_word,
    input  logic [stbs_pkg::LEN_W-1:0] i_table_length,
    input  stbs_pkg::t_ctrl_cmd      i_cmd,
    output stbs_pkg::t_ctrl_sts      o_sts,
    output logic                     o_done,
    output stbs_pkg::t_out_word      o_rsp_word
);

    import stbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [LEN_W-1:0]         len_eff;
    logic signed [POS_W-1:0]  high0;
    logic signed [POS_W-1:0]  mid0;

    logic signed [POS_W-1:0]  r_low, n_low;
    logic signed [POS_W-1:0]  r_high, n_high;
    logic signed [POS_W-1:0]  r_mid, n_mid;
    logic signed [DATA_W-1:0] r_key;
    logic                     r_floor;

    logic signed [POS_W-1:0]  low_up, high_dn, mid_up, mid_dn;
    logic signed [DATA_W-1:0] probe;
    logic                     eq, lt;

    logic                     ram_en;
    logic [AW-1:0]            ram_addr;
    logic [DATA_W-1:0]        ram_rdata;

    logic                     r_done;
    t_out_word                r_rsp, n_rsp;

    // Effective length: clamped to the table depth.
    always_comb begin
        if (32'(i_table_length) > TABLE_DEPTH) begin
            len_eff = LEN_W'(TABLE_DEPTH);
        end else begin
            len_eff = i_table_length;
        end
    end

    assign high0 = $signed({1'b0, len_eff}) - POS_W'(1);
    assign mid0  = high0 >>> 1;

    assign probe   = $signed(ram_rdata);
    assign eq      = (probe == r_key);
    assign lt      = (probe < r_key);

    // Both successor midpoints are formed from registers, in parallel with the compare.
    assign low_up  = r_mid + POS_W'(1);
    assign high_dn = r_mid - POS_W'(1);
    assign mid_up  = low_up + ((r_high - low_up) >>> 1);
    assign mid_dn  = r_low + ((high_dn - r_low) >>> 1);

    assign o_sts.idx_ok    = (32'(i_req_word.entry_index) < TABLE_DEPTH);
    assign o_sts.empty     = (len_eff == '0);
    assign o_sts.hit       = eq;
    assign o_sts.exhausted = lt ? (low_up > r_high) : (r_low > high_dn);

    always_comb begin
        n_low  = r_low;
        n_high = r_high;
        n_mid  = r_mid;
        if (i_cmd.init) begin
            n_low  = '0;
            n_high = high0;
            n_mid  = mid0;
        end else if (i_cmd.step) begin
            if (lt) begin
                n_low = low_up;
                n_mid = mid_up;
            end else begin
                n_high = high_dn;
                n_mid  = mid_dn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_low  <= n_low;
        r_high <= n_high;
        r_mid  <= n_mid;
        if (i_cmd.init) begin
            r_key   <= i_req_word.search_key;
            r_floor <= i_req_word.floor_mode;
        end
    end

    // Table port: write, first probe, or next probe.
    assign ram_en = i_cmd.ram_wr | i_cmd.init | i_cmd.step;

    always_comb begin
        if (i_cmd.ram_wr) begin
            ram_addr = AW'(i_req_word.entry_index);
        end else if (i_cmd.init) begin
            ram_addr = AW'(unsigned'(mid0));
        end else begin
            ram_addr = AW'(unsigned'(n_mid));
        end
    end

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (i_cmd.ram_wr),
        .i_addr  (ram_addr),
        .i_wdata (i_req_word.entry_value),
        .o_rdata (ram_rdata)
    );

    // Result word.
    always_comb begin
        n_rsp = r_rsp;
        if (i_cmd.emit_empty) begin
            n_rsp.found    = 1'b0;
            n_rsp.position = i_req_word.floor_mode ? -POS_W'(1) : '0;
        end else if (i_cmd.emit_probe) begin
            n_rsp.found = eq;
            if (eq) begin
                n_rsp.position = r_mid;
            end else if (r_floor) begin
                n_rsp.position = lt ? r_high : high_dn;
            end else begin
                n_rsp.position = lt ? low_up : r_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit_empty | i_cmd.emit_probe;
        end
    end

    assign o_done     = r_done;
    assign o_rsp_word = r_rsp;

endmodule

[hdl/stbs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer: accepts request words and steps the search one probe a cycle.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_func,
    input  stbs_pkg::t_ctrl_sts i_sts,
    output stbs_pkg::t_ctrl_cmd o_cmd,
    output logic                busy
);

    import stbs_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign accept = start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func == FUNC_SEARCH && !i_sts.empty) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.hit || i_sts.exhausted) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func == FUNC_WRITE) begin
                    o_cmd.ram_wr = i_sts.idx_ok;
                end
                if (accept && i_func == FUNC_SEARCH) begin
                    o_cmd.init       = 1'b1;
                    o_cmd.emit_empty = i_sts.empty;
                end
            end
            S_PROBE: begin
                o_cmd.step       = 1'b1;
                o_cmd.emit_probe = i_sts.hit | i_sts.exhausted;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state == S_PROBE);

endmodule

[hdl/sorted_table_binary_search_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Binary search over a table of signed words held in on-chip RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Request words go in on i_req_word, taken when start is high and busy
//    is low. func selects a table write or a search.
//  - A write stores entry_value at entry_index (ignored past the table
//    depth); it finishes in the accept cycle and gives no result.
//  - A search looks up search_key among the first table_length entries.
//    The result word (found, position) is shown on o_rsp_word for a single
//    cycle with o_done high. The receiver cannot stall; it must take it.
//  - Timing: one probe per cycle, the result appears the cycle after the
//    last probe. A 1024-entry table needs at most 11 probes; an empty table
//    answers the cycle after accept. The single RAM port read per cycle sets
//    the pace.
//  - A new request may be accepted in the same cycle o_done is shown.
//  - table_length sits in an APB register at byte address 0 (pready tied
//    high, prdata always shows it). Write it only while the unit is idle.
//  - Reset clears table_length and the sequencer; table contents are
//    undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  stbs_pkg::t_in_word            i_req_word,
    // result channel
    output logic                          o_done,
    output stbs_pkg::t_out_word           o_rsp_word,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stbs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import stbs_pkg::*;

    logic [LEN_W-1:0] r_table_length;
    t_ctrl_cmd        cmd;
    t_ctrl_sts        sts;
    logic             cfg_wr;

    // Register write on the APB access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_TABLE_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= '0;
        end else if (cfg_wr) begin
            r_table_length <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = {{(32-LEN_W){1'b0}}, r_table_length};

    // Sequencer.
    stbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_req_word.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Table, bounds and result.
    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_word     (i_req_word),
        .i_table_length (r_table_length),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_done         (o_done),
        .o_rsp_word     (o_rsp_word)
    );

endmodule

[hdl/stbs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the search unit, bound to the top level.
// ----------------------------------------------------------------------------
module stbs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  stbs_pkg::t_in_word            i_req_word,
    input  logic                          o_done,
    input  stbs_pkg::t_out_word           o_rsp_word,
    input  logic [31:0]                   prdata
);

    import stbs_pkg::*;

    // A write word never occupies the unit.
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_word.func == FUNC_WRITE |=> !busy)
        else $error("busy after write word");

    // A search on a non-empty table starts probing.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_word.func == FUNC_SEARCH && prdata != 0 |=> busy)
        else $error("search did not start");

    // Empty table answers with a miss, without probing.
    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_word.func == FUNC_SEARCH && prdata == 0
        |=> o_done && !o_rsp_word.found)
        else $error("empty table search result wrong");

    // Result shows only once the search has finished.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result while busy");

    // A hit is always a real table position.
    a_hit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp_word.found |-> !o_rsp_word.position[POS_W-1])
        else $error("negative hit position");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (.*);
